// ----- hdl/u8ve_pkg.sv -----
// Shared constants, types and helpers for the UTF-8 validate/escape block.
// No dependencies; imported by every module of the block.
package u8ve_pkg;

	localparam logic [7:0] BSLASH         = 8'h5C;
	localparam logic [7:0] LOWER_X        = 8'h78;
	localparam logic [7:0] CONT_MASK      = 8'hC0;
	localparam logic [7:0] CONT_TAG       = 8'h80;
	localparam logic [7:0] HEX_BASE_NUM   = 8'h30;
	localparam logic [7:0] HEX_BASE_ALPHA = 8'h57;

	// token kinds at the scan position
	localparam logic [1:0] TOK_BSL  = 2'd0;
	localparam logic [1:0] TOK_SEQ  = 2'd1;
	localparam logic [1:0] TOK_BAD  = 2'd2;
	localparam logic [1:0] TOK_WAIT = 2'd3;

	typedef logic [3:0][7:0] win_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] len;   // bytes consumed
		logic [2:0] outs;  // result bytes produced
	} tok_t;

	// announced sequence length of a lead byte, 0 if it cannot lead
	function automatic logic [2:0] lead_len(logic [7:0] lead);
		logic [2:0] res;
		if (lead < 8'h80)                        res = 3'd1;
		else if (lead >= 8'hC2 && lead <= 8'hDF) res = 3'd2;
		else if (lead >= 8'hE0 && lead <= 8'hEF) res = 3'd3;
		else if (lead >= 8'hF0 && lead <= 8'hF4) res = 3'd4;
		else                                     res = 3'd0;
		return res;
	endfunction

	// lower-case hex digit of a nibble
	function automatic logic [7:0] hex_digit(logic [3:0] d);
		logic [7:0] res;
		if (d <= 4'd9) res = HEX_BASE_NUM + {4'h0, d};
		else           res = HEX_BASE_ALPHA + {4'h0, d};
		return res;
	endfunction

	// bytes of w starting at s; positions past the end read as zero
	function automatic win_t pick(win_t w, logic [2:0] s);
		logic [2:0] ix;
		win_t res;
		for (int k = 0; k < 4; k++) begin
			ix = s + 3'(k);
			res[k] = ix[2] ? 8'h00 : w[ix[1:0]];
		end
		return res;
	endfunction

endpackage

// ----- hdl/u8ve_in_if.sv -----
// Input channel of the UTF-8 validate/escape block: one raw path byte per word.
// No dependencies.
interface u8ve_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       path_end;

	modport source(output valid, in_byte, path_end, input ready);
	modport sink(input valid, in_byte, path_end, output ready);
endinterface

// ----- hdl/u8ve_out_if.sv -----
// Output channel of the UTF-8 validate/escape block: one escaped byte per word.
// No dependencies.
interface u8ve_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       text_end;
	logic       all_valid;

	modport source(output valid, out_byte, run_last, text_end, all_valid, input ready);
	modport sink(input valid, out_byte, run_last, text_end, all_valid, output ready);
endinterface

// ----- hdl/utf8_validate_escape_core.sv -----
// Strict UTF-8 validation and escaping of a path, one byte per word.
// The first result byte of a word passes from the scan register into the output register once that is free.
// Throughput: one result byte per cycle while esc.ready allows, set by the single output register;
// a word that yields several bytes holds the input until its last result byte is emitted.
// Reset: arst_n asynchronously clears scan control, pending count, invalid flag and output
// valid; pending bytes are undefined until written and need no clearing pass.
module utf8_validate_escape_core import u8ve_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	u8ve_in_if.sink       raw,
	u8ve_out_if.source    esc
);

	// scan register: bytes of the word under work (pending bytes plus the new one)
	win_t       w_q;
	logic [2:0] n_q;       // bytes in w_q, 1..4
	logic [2:0] start_q;   // scan position
	logic [1:0] j_q;       // result byte within the current token
	logic       end_q;     // word closes the path
	logic       busy_q;

	// bytes of an incomplete sequence carried to the next word
	logic [2:0][7:0] pb_q;
	logic [1:0]      pc_q;
	logic            seen_q;   // an invalid lead was escaped in this path

	// output register
	logic       o_valid_q;
	logic [7:0] o_byte_q;
	logic       o_run_q;
	logic       o_text_q;
	logic       o_allv_q;

	win_t       win_cur, win_nxt, rem_win, new_w;
	logic [2:0] avail_cur, avail_nxt, nstart, rem_start;
	tok_t       tok_cur, tok_nxt;
	logic       is_wait, tok_done, nxt_none, step_last;
	logic       slot_free, emit, done, acc;
	logic [1:0] rem_cnt, pend_c;
	logic [2:0][7:0] pend_b;
	logic [7:0] res_byte;
	logic       seen_now;

	// look at the token under the scan position and at the one after it
	assign win_cur   = pick(w_q, start_q);
	assign avail_cur = n_q - start_q;
	assign nstart    = start_q + tok_cur.len;
	assign win_nxt   = pick(w_q, nstart);
	assign avail_nxt = n_q - nstart;

	u8ve_classify u_cls_cur (
		.win  (win_cur),
		.avail(avail_cur),
		.last (end_q),
		.tok  (tok_cur)
	);

	u8ve_classify u_cls_nxt (
		.win  (win_nxt),
		.avail(avail_nxt),
		.last (end_q),
		.tok  (tok_nxt)
	);

	assign is_wait   = (tok_cur.kind == TOK_WAIT);
	assign tok_done  = ({1'b0, j_q} == (tok_cur.outs - 3'd1));
	assign nxt_none  = (nstart == n_q);
	// last byte of the word: nothing left, or only a sequence that must wait
	assign step_last = tok_done && (nxt_none || (tok_nxt.kind == TOK_WAIT));

	assign slot_free = !o_valid_q || esc.ready;
	assign emit      = busy_q && !is_wait && slot_free;
	assign done      = busy_q && (is_wait || (emit && step_last));

	// what stays pending once the word is finished; the path end flushes everything
	assign rem_start = is_wait ? start_q : nstart;
	assign rem_win   = pick(w_q, rem_start);
	assign rem_cnt   = end_q ? 2'd0 : 2'(n_q - rem_start);

	// take the next word in the cycle the current one finishes
	assign raw.ready = !busy_q || done;
	assign acc       = raw.valid && raw.ready;
	assign pend_b    = done ? rem_win[2:0] : pb_q;
	assign pend_c    = done ? rem_cnt : pc_q;

	always_comb begin
		new_w = '0;
		for (int k = 0; k < 3; k++) begin
			if (2'(k) < pend_c) new_w[k] = pend_b[k];
		end
		new_w[pend_c] = raw.in_byte;
	end

	// result byte for the current token
	always_comb begin
		case (tok_cur.kind)
			TOK_BSL: res_byte = BSLASH;
			TOK_SEQ: res_byte = win_cur[j_q];
			TOK_BAD: begin
				case (j_q)
					2'd0:    res_byte = BSLASH;
					2'd1:    res_byte = LOWER_X;
					2'd2:    res_byte = hex_digit(win_cur[0][7:4]);
					default: res_byte = hex_digit(win_cur[0][3:0]);
				endcase
			end
			default: res_byte = 8'h00;
		endcase
	end

	assign seen_now = seen_q || (tok_cur.kind == TOK_BAD);

	// scan control: advance within a token, then to the next; reload on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 3'd0;
			j_q     <= 2'd0;
			n_q     <= 3'd0;
			end_q   <= 1'b0;
			pc_q    <= 2'd0;
			seen_q  <= 1'b0;
		end else begin
			if (acc) begin
				busy_q  <= 1'b1;
				start_q <= 3'd0;
				j_q     <= 2'd0;
				n_q     <= {1'b0, pend_c} + 3'd1;
				end_q   <= raw.path_end;
			end else begin
				if (emit) begin
					if (tok_done) begin
						start_q <= nstart;
						j_q     <= 2'd0;
					end else begin
						j_q <= j_q + 2'd1;
					end
				end
				if (done) busy_q <= 1'b0;
			end
			if (done) pc_q <= rem_cnt;
			// clear the invalid flag at the path end, else latch any escaped lead
			if (done && end_q) seen_q <= 1'b0;
			else if (emit && (tok_cur.kind == TOK_BAD)) seen_q <= 1'b1;
		end
	end

	// payload registers: no reset
	always_ff @(posedge clk) begin
		if (acc) w_q <= new_w;
		if (done) pb_q <= rem_win[2:0];
		if (emit) begin
			o_byte_q <= res_byte;
			o_run_q  <= step_last;
			o_text_q <= step_last && end_q;
			o_allv_q <= step_last && end_q && !seen_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (slot_free) begin
			o_valid_q <= emit;
		end
	end

	assign esc.valid     = o_valid_q;
	assign esc.out_byte  = o_byte_q;
	assign esc.run_last  = o_run_q;
	assign esc.text_end  = o_text_q;
	assign esc.all_valid = o_allv_q;

	a_text_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		esc.valid && esc.text_end |-> esc.run_last)
		else $error("text_end without run_last");

	a_valid_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		esc.valid && esc.all_valid |-> esc.text_end)
		else $error("all_valid outside text_end");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (start_q < n_q))
		else $error("scan position past the word");

	a_end_never_waits: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && end_q |-> !is_wait)
		else $error("held sequence at path end");

	a_end_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		done && end_q |=> (pc_q == 2'd0))
		else $error("bytes left pending after path end");

endmodule

// ----- hdl/u8ve_classify.sv -----
// Classifies the token at a scan position of up to four bytes.
// Depends on u8ve_pkg.
module u8ve_classify import u8ve_pkg::*; (
	input  win_t       win,
	input  logic [2:0] avail,
	input  logic       last,
	output tok_t       tok
);

	logic [7:0] lead;
	logic [2:0] len;
	logic [2:0] m;
	logic       mismatch;
	logic       range_ok;

	always_comb begin
		lead = win[0];
		len  = lead_len(lead);
		m    = (avail < len) ? avail : len;
		mismatch = 1'b0;
		for (int i = 1; i < 4; i++) begin
			if ((3'(i) < m) && ((win[i] & CONT_MASK) != CONT_TAG)) mismatch = 1'b1;
		end
		// overlong, surrogate and above-range forms show in the second byte
		case (lead)
			8'hE0:   range_ok = (win[1] >= 8'hA0);
			8'hED:   range_ok = (win[1] <  8'hA0);
			8'hF0:   range_ok = (win[1] >= 8'h90);
			8'hF4:   range_ok = (win[1] <  8'h90);
			default: range_ok = 1'b1;
		endcase

		tok = '{kind: TOK_SEQ, len: len, outs: len};
		if (lead == BSLASH) begin
			tok = '{kind: TOK_BSL, len: 3'd1, outs: 3'd2};
		end else if (len == 3'd0) begin
			tok = '{kind: TOK_BAD, len: 3'd1, outs: 3'd4};
		end else if (len == 3'd1) begin
			tok = '{kind: TOK_SEQ, len: 3'd1, outs: 3'd1};
		end else if (mismatch) begin
			tok = '{kind: TOK_BAD, len: 3'd1, outs: 3'd4};
		end else if (avail < len) begin
			if (last) tok = '{kind: TOK_BAD, len: 3'd1, outs: 3'd4};
			else      tok = '{kind: TOK_WAIT, len: 3'd0, outs: 3'd0};
		end else if (!range_ok) begin
			tok = '{kind: TOK_BAD, len: 3'd1, outs: 3'd4};
		end
	end

endmodule
